/* design/wswc_pkg.sv */
// ============================================================================
// wswc_pkg - shared types and constants for the working-set window counter
// Field widths, page mapping, operation codes and small helper functions.
// ============================================================================
package wswc_pkg;

    // Payload widths
    localparam int ADDR_W   = 32;
    localparam int CFG_W    = 5;
    localparam int WNUM_W   = 16;
    localparam int SIZE_W   = 5;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;

    // Window store depth and page mapping (page size is a power of two)
    localparam int MAX_WINDOW = 20;
    localparam int PAGE_BYTES = 2;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = CFG_W'(20);

    // Operation codes
    localparam logic [0:0] OP_ACCESS = 1'b0;
    localparam logic [0:0] OP_FLUSH  = 1'b1;

    // Registered request handed from the input stage
    typedef struct packed {
        logic [0:0]        op;
        logic [PAGE_W-1:0] page;
    } t_item;

    // Control into the page store
    typedef struct packed {
        logic              access;
        logic              close;
        logic [PAGE_W-1:0] page;
    } t_cam_req;

    // Status out of the page store
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
    } t_cam_rsp;

    // Zero means one, above the store depth means the store depth
    function automatic logic [CNT_W-1:0] eff_len(input logic [CFG_W-1:0] wl);
        logic [CNT_W-1:0] res;
        if (wl == '0) begin
            res = CNT_W'(1);
        end else if (32'(wl) > MAX_WINDOW) begin
            res = CNT_W'(MAX_WINDOW);
        end else begin
            res = CNT_W'(wl);
        end
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_size(input logic [CNT_W-1:0] c);
        logic [SIZE_W-1:0] res;
        if (32'(c) > SIZE_MAX) begin
            res = SIZE_W'(SIZE_MAX);
        end else begin
            res = SIZE_W'(c);
        end
        return res;
    endfunction

endpackage

/* design/wswc_if.sv */
// ============================================================================
// wswc_if - valid/ready channels of the working-set window counter
// Access requests, window results and the window length write channel.
// ============================================================================
interface wswc_in_if;
    logic                       valid;
    logic                       ready;
    logic [0:0]                 operation;
    logic [wswc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface wswc_out_if;
    logic                        valid;
    logic                        ready;
    logic [wswc_pkg::WNUM_W-1:0] window_number;
    logic [wswc_pkg::SIZE_W-1:0] working_set_size;

    modport source (output valid, output window_number, output working_set_size,
                    input ready);
    modport sink   (input valid, input window_number, input working_set_size,
                    output ready);
endinterface

interface wswc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wswc_pkg::CFG_W-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

/* design/working_set_window_counter.sv */
// ============================================================================
// working_set_window_counter - top level
// Counts distinct pages per fixed window of accesses and emits one result
// per closed window (or per flush of a non-empty partial window).
// ============================================================================
//
// Channel  | Dir | Payload                             | Handshake
// ---------+-----+-------------------------------------+------------
// i_req    | in  | operation, address                  | valid/ready
// o_rsp    | out | window_number, working_set_size     | valid/ready
// i_cfg    | in  | window_length                       | valid/ready
//
// One request per cycle while no result waits for o_rsp.ready. A request is
// taken into the input register; its result (if any) is written to the result
// register. The page compare, the count update and the window close are
// combinational between the input register and the result register. A result
// waiting in the result register holds the held request, whether or not that
// request closes a window; ready on i_req then follows o_rsp.ready.
// Reset (synchronous, active low) clears counters, valids and sets the window
// length to 20. The page store needs no clearing; its fill count gates it.
//
module working_set_window_counter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wswc_in_if.sink    i_req,
    wswc_out_if.source o_rsp,
    wswc_cfg_if.sink   i_cfg
);

    // Window length register; the user writes it only while idle, the block does not enforce this
    logic [wswc_pkg::CFG_W-1:0] r_window_length;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= wswc_pkg::WINDOW_LENGTH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_window_length <= i_cfg.window_length;
        end
    end

    // Input register
    logic            in_valid;
    wswc_pkg::t_item in_item;
    logic            proc;

    wswc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (proc),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // Window state
    logic [wswc_pkg::CNT_W-1:0]  r_win_pos;
    logic [wswc_pkg::WNUM_W-1:0] r_win_cnt;

    // Result register
    logic                        r_out_valid;
    logic [wswc_pkg::WNUM_W-1:0] r_out_num;
    logic [wswc_pkg::SIZE_W-1:0] r_out_size;

    logic                     is_flush;
    logic                     access;
    logic                     flush_emit;
    logic                     close_acc;
    logic                     emit;
    logic [wswc_pkg::CNT_W:0] pos_next;
    logic [wswc_pkg::CNT_W-1:0] emit_count;

    wswc_pkg::t_cam_req cam_req;
    wswc_pkg::t_cam_rsp cam_rsp;

    // Process the held request when the result register can take a result
    assign proc       = in_valid && (!r_out_valid || o_rsp.ready);
    assign is_flush   = (in_item.op == wswc_pkg::OP_FLUSH);
    assign access     = proc && !is_flush;
    // Flush of an empty window is consumed silently
    assign flush_emit = proc && is_flush && (r_win_pos != '0);
    assign pos_next   = {1'b0, r_win_pos} + 1'b1;
    // >= covers a length lowered mid-window
    assign close_acc  = access &&
                        (pos_next >= {1'b0, wswc_pkg::eff_len(r_window_length)});
    assign emit       = close_acc || flush_emit;
    assign emit_count = is_flush ? cam_rsp.count : cam_rsp.count_next;

    assign cam_req.access = access;
    assign cam_req.close  = emit;
    assign cam_req.page   = in_item.page;

    wswc_page_cam u_page_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cam_req),
        .o_rsp   (cam_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_pos <= '0;
            r_win_cnt <= '0;
        end else begin
            if (emit) begin
                r_win_pos <= '0;
                r_win_cnt <= r_win_cnt + 1'b1;   // wraps
            end else if (access) begin
                r_win_pos <= pos_next[wswc_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_num  <= r_win_cnt;
            r_out_size <= wswc_pkg::sat_size(emit_count);
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.window_number    = r_out_num;
    assign o_rsp.working_set_size = r_out_size;

`ifndef ASSERT_OFF
    // Position never reaches the store depth between requests
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_win_pos) < wswc_pkg::MAX_WINDOW)
        else $error("window position out of range");

    // Distinct pages never exceed accesses taken into the window
    a_count_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cam_rsp.count <= r_win_pos)
        else $error("distinct count exceeds window position");

    // A closed window leaves a result and an empty window behind
    a_emit_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_valid && (r_win_pos == '0) && (cam_rsp.count == '0)))
        else $error("window close not reflected");

    // Window index moves only with a result
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit |=> $stable(r_win_cnt))
        else $error("window index changed without a result");
`endif

endmodule

/* design/wswc_in_stage.sv */
// ============================================================================
// wswc_in_stage - input register
// Captures one request, maps the address to its page number.
// ============================================================================
module wswc_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wswc_in_if.sink          i_req,
    input  logic             i_take,
    output logic             o_valid,
    output wswc_pkg::t_item  o_item
);

    logic            r_valid;
    wswc_pkg::t_item r_item;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.op   <= i_req.operation;
            r_item.page <= i_req.address[wswc_pkg::ADDR_W-1:wswc_pkg::PAGE_SHIFT];
        end
    end

endmodule

/* design/wswc_page_cam.sv */
// ============================================================================
// wswc_page_cam - distinct page store
// Parallel compare of a page against the valid entries, append on a miss.
// ============================================================================
module wswc_page_cam (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wswc_pkg::t_cam_req i_req,
    output wswc_pkg::t_cam_rsp o_rsp
);

    logic [wswc_pkg::PAGE_W-1:0] r_pages [wswc_pkg::MAX_WINDOW];
    logic [wswc_pkg::CNT_W-1:0]  r_count;
    logic [wswc_pkg::MAX_WINDOW-1:0] hit_vec;
    logic hit;

    // Only entries below the fill count take part
    always_comb begin
        for (int i = 0; i < wswc_pkg::MAX_WINDOW; i++) begin
            hit_vec[i] = (32'(i) < 32'(r_count)) && (r_pages[i] == i_req.page);
        end
    end

    assign hit              = |hit_vec;
    assign o_rsp.count      = r_count;
    assign o_rsp.count_next = hit ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.close) begin
            r_count <= '0;
        end else if (i_req.access) begin
            r_count <= o_rsp.count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.access && !hit && (32'(r_count) < wswc_pkg::MAX_WINDOW)) begin
            r_pages[r_count[wswc_pkg::IDX_W-1:0]] <= i_req.page;
        end
    end

endmodule

/* tb/sv/wswc_window_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// wswc_window_checker - result checker for the working-set window counter
// Watches the request, result and window length channels, keeps its own
// copy of the window state, and compares every result with the prediction.
// ============================================================================
module wswc_window_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [0:0]                  i_req_operation,
    input  logic [wswc_pkg::ADDR_W-1:0] i_req_address,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic [wswc_pkg::WNUM_W-1:0] i_rsp_window_number,
    input  logic [wswc_pkg::SIZE_W-1:0] i_rsp_working_set_size,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [wswc_pkg::CFG_W-1:0]  i_cfg_window_length,
    output int                          o_pending_results,
    output int                          o_mismatch_count
);

    typedef struct {
        logic [wswc_pkg::WNUM_W-1:0] number;
        logic [wswc_pkg::SIZE_W-1:0] size;
    } t_window_result;

    t_window_result    expected_windows[$];

    // Shadow of the window state
    logic [wswc_pkg::PAGE_W-1:0] window_pages[wswc_pkg::MAX_WINDOW];
    int unsigned                 page_count;
    int unsigned                 fill_position;
    logic [wswc_pkg::WNUM_W-1:0] next_window;
    logic [wswc_pkg::CFG_W-1:0]  window_len;
    int                          mismatches;

    task automatic close_window();
        t_window_result res;
        res.number = next_window;
        res.size   = (page_count > 31) ? wswc_pkg::SIZE_W'(31)
                                       : wswc_pkg::SIZE_W'(page_count);
        expected_windows.push_back(res);
        next_window   = next_window + 1'b1;
        page_count    = 0;
        fill_position = 0;
    endtask

    // One accepted request: flush or page lookup, maybe a closed window
    task automatic predict_window_close(input logic [0:0] op,
                                        input logic [wswc_pkg::ADDR_W-1:0] addr);
        logic [wswc_pkg::PAGE_W-1:0] page;
        bit                          hit;
        int unsigned                 limit;
        if (op == wswc_pkg::OP_FLUSH) begin
            if (fill_position != 0) begin
                close_window();
            end
        end else begin
            page = wswc_pkg::PAGE_W'(addr / wswc_pkg::PAGE_BYTES);
            hit  = 1'b0;
            for (int i = 0; i < wswc_pkg::MAX_WINDOW; i++) begin
                if (i < page_count && window_pages[i] == page) begin
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (page_count < wswc_pkg::MAX_WINDOW) begin
                    window_pages[page_count] = page;
                end
                page_count++;
            end
            fill_position++;
            if (window_len == '0) begin
                limit = 1;
            end else if (window_len > wswc_pkg::MAX_WINDOW) begin
                limit = wswc_pkg::MAX_WINDOW;
            end else begin
                limit = window_len;
            end
            if (fill_position >= limit) begin
                close_window();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result exp_res;
        if (!i_rst_n) begin
            expected_windows.delete();
            page_count    = 0;
            fill_position = 0;
            next_window   = '0;
            window_len    = wswc_pkg::WINDOW_LENGTH_RESET;
            mismatches    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_len = i_cfg_window_length;
            end
            if (i_req_valid && i_req_ready) begin
                predict_window_close(i_req_operation, i_req_address);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_windows.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected window result: window %0d size %0d",
                                 $realtime, i_rsp_window_number, i_rsp_working_set_size);
                    end
                    mismatches++;
                end else begin
                    exp_res = expected_windows.pop_front();
                    if (exp_res.number !== i_rsp_window_number ||
                        exp_res.size !== i_rsp_working_set_size) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected win %0d size %0d, got win %0d size %0d",
                                     $realtime, exp_res.number, exp_res.size,
                                     i_rsp_window_number, i_rsp_working_set_size);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending_results <= expected_windows.size();
        o_mismatch_count  <= mismatches;
    end

endmodule

/* tb/sv/working_set_window_counter_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// working_set_window_counter_test - testbench top
// Drives access and flush requests with bursty timing, writes the window
// length between phases, stalls the result side, and reports the verdict
// from the checker's mismatch count.
// ============================================================================
module working_set_window_counter_test;

    // Run sizing
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;    // a request with no result still in flight
    localparam int HOLD_CYCLES  = 300;  // long result hold-off

    logic i_clk;
    logic i_rst_n;

    wswc_in_if  req_if();
    wswc_out_if rsp_if();
    wswc_cfg_if cfg_if();

    int pending_results;
    int mismatch_count;

    // Sender burst state
    int burst_left;

    // Long hold-off requests to the receiver; it serves them in its own process
    int hold_requests;

    // Addresses reused inside a phase so pages repeat within windows
    logic [wswc_pkg::ADDR_W-1:0] addr_pool[8];

    working_set_window_counter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    wswc_window_checker checker_inst (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_req_valid            (req_if.valid),
        .i_req_ready            (req_if.ready),
        .i_req_operation        (req_if.operation),
        .i_req_address          (req_if.address),
        .i_rsp_valid            (rsp_if.valid),
        .i_rsp_ready            (rsp_if.ready),
        .i_rsp_window_number    (rsp_if.window_number),
        .i_rsp_working_set_size (rsp_if.working_set_size),
        .i_cfg_valid            (cfg_if.valid),
        .i_cfg_ready            (cfg_if.ready),
        .i_cfg_window_length    (cfg_if.window_length),
        .o_pending_results      (pending_results),
        .o_mismatch_count       (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung block ends the run here
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: phases of steady, random, mostly-ready and mostly-stalled
    // ready, plus long hold-offs on request from the stimulus.
    initial begin
        int holds_served;
        int hold_left;
        int rx_mode;
        int rx_phase_left;
        holds_served  = 0;
        hold_left     = 0;
        rx_mode       = 0;
        rx_phase_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(20, 200);
                end
                rx_phase_left--;
                case (rx_mode)
                    0: begin
                        rsp_if.ready <= 1'b1;
                    end
                    1: begin
                        rsp_if.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        rsp_if.ready <= ($urandom_range(0, 7) != 0);
                    end
                    default: begin
                        rsp_if.ready <= ($urandom_range(0, 7) == 0);
                    end
                endcase
            end
        end
    end

    // Offer one request and hold it until the block takes it. Between bursts
    // valid drops for a random gap; some bursts are long and gap-free.
    task automatic send_request(input logic [0:0] op,
                                input logic [wswc_pkg::ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.address   <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
    endtask

    // Length writes happen only with the block idle: no request offered,
    // every predicted result drained, and a DRAIN_CYCLES wait for a last
    // access that closes no window.
    task automatic set_window_length(input logic [wswc_pkg::CFG_W-1:0] len);
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.window_length <= len;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Random request: mostly accesses into the phase's address pool (often
    // the other address of the same page), some small or wide addresses,
    // and the odd flush of a partial window.
    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_request(wswc_pkg::OP_FLUSH, $urandom);
        end else if (r < 65) begin
            send_request(wswc_pkg::OP_ACCESS, addr_pool[$urandom_range(0, 7)] ^
                                              wswc_pkg::ADDR_W'($urandom_range(0, 1)));
        end else if (r < 75) begin
            send_request(wswc_pkg::OP_ACCESS, wswc_pkg::ADDR_W'($urandom_range(0, 63)));
        end else begin
            send_request(wswc_pkg::OP_ACCESS, $urandom);
        end
    endtask

    initial begin
        int sent;
        int phase;
        int n;
        logic [wswc_pkg::CFG_W-1:0] len;

        // Every input known from time zero
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.operation     <= wswc_pkg::OP_ACCESS;
        req_if.address       <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.window_length <= '0;
        hold_requests        <= 0;
        burst_left = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed part ---
        // Length 4: address extremes, both addresses of the lowest and the
        // highest page, so the window holds two pages.
        set_window_length(wswc_pkg::CFG_W'(4));
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_0000);
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_0001);
        send_request(wswc_pkg::OP_ACCESS, 32'hFFFF_FFFF);
        send_request(wswc_pkg::OP_ACCESS, 32'hFFFF_FFFE);
        // flush right after a closed window: empty, nothing comes out
        send_request(wswc_pkg::OP_FLUSH, 32'hFFFF_FFFF);
        // partial window closed by flush
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_0002);
        send_request(wswc_pkg::OP_ACCESS, 32'h8000_0000);
        send_request(wswc_pkg::OP_FLUSH, 32'h0000_0000);

        // Length zero acts as one
        set_window_length(wswc_pkg::CFG_W'(0));
        send_request(wswc_pkg::OP_ACCESS, 32'h1234_5678);
        send_request(wswc_pkg::OP_FLUSH, 32'h5555_5555);

        // Length lowered below the fill level mid-window: the next access
        // closes it
        set_window_length(wswc_pkg::CFG_W'(20));
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_000A);
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_000B);
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_000C);
        send_request(wswc_pkg::OP_ACCESS, 32'h0000_000A);
        set_window_length(wswc_pkg::CFG_W'(3));
        send_request(wswc_pkg::OP_ACCESS, 32'h5555_5555);
        set_window_length(wswc_pkg::CFG_W'(1));
        send_request(wswc_pkg::OP_ACCESS, 32'hAAAA_AAAA);

        // --- Random part ---
        // Phases of fresh length and address pool; the first ones take the
        // length extremes (store depth, above it, one, zero).
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       len = wswc_pkg::CFG_W'(20);
                1:       len = wswc_pkg::CFG_W'(31);
                2:       len = wswc_pkg::CFG_W'(1);
                3:       len = wswc_pkg::CFG_W'(0);
                4:       len = wswc_pkg::CFG_W'(21);
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        len = wswc_pkg::CFG_W'($urandom_range(0, 31));
                    end else begin
                        len = wswc_pkg::CFG_W'($urandom_range(1, 8));
                    end
                end
            endcase
            set_window_length(len);
            foreach (addr_pool[i]) addr_pool[i] = $urandom;

            // Long result hold-off while requests keep coming: the block
            // fills up and drops ready on its input.
            if (phase == 0 || phase == 5) begin
                hold_requests <= hold_requests + 1;
            end

            n = $urandom_range(40, 160);
            repeat (n) begin
                send_random_request();
                sent++;
            end
            // trace end: on about half the phases, flush whatever partial window is left
            if ($urandom_range(0, 1) == 0) begin
                send_request(wswc_pkg::OP_FLUSH, $urandom);
            end
            phase++;
        end

        // --- Drain and verdict ---
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
